>>> hw/rtl/rsi_pkg.sv
// shared types and constants for the ray against sphere intersection block
// no dependencies; imported by the front, back and top modules of the block
package rsi_pkg;

  // front pipeline: offset, products, sums, magnitudes, partials, squares, discriminant
  localparam int FR_STAGES  = 7;
  // back pipeline: one root bit per stage, three numerator stages, one quotient bit per stage
  localparam int SQ_STAGES  = 66;
  localparam int NUM_STAGES = 3;
  localparam int DIV_STAGES = 32;
  localparam int BK_STAGES  = SQ_STAGES + NUM_STAGES + DIV_STAGES;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_CENTER_X      = 2'd0;
  localparam cfg_idx_t REG_CENTER_Y      = 2'd1;
  localparam cfg_idx_t REG_CENTER_Z      = 2'd2;
  localparam cfg_idx_t REG_SPHERE_RADIUS = 2'd3;

  localparam logic [30:0] RADIUS_RESET = 31'd65536;
  localparam logic [31:0] T_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] T_MIN = 32'h8000_0000;

  // classified item handed from front to back
  typedef struct packed {
    logic         hit;
    logic [66:0]  h;    // d.oc, signed Q32.32
    logic [63:0]  a;    // d.d, unsigned Q32.32
    logic [131:0] rad;  // quarter discriminant, Q64.64
  } mid_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] t_near;
    logic [31:0] t_far;
  } out_item_t;

endpackage

>>> hw/rtl/rsi_fifo.sv
// small register queue with push/full and pop/empty sides
// depends on nothing; used between front and back and at the result side
module rsi_fifo #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    cnt;
  logic             do_push;
  logic             do_pop;

  assign full    = cnt == CW'(DEPTH);
  assign empty   = cnt == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt <= cnt + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

endmodule

>>> hw/rtl/rsi_front.sv
// front pipeline: forms a, h, c and the quarter discriminant, classifies hit or miss
// depends on rsi_pkg; feeds the mid queue
module rsi_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic [31:0]         origin_x,
  input  logic [31:0]         origin_y,
  input  logic [31:0]         origin_z,
  input  logic [31:0]         dir_x,
  input  logic [31:0]         dir_y,
  input  logic [31:0]         dir_z,
  input  logic [31:0]         center_x,
  input  logic [31:0]         center_y,
  input  logic [31:0]         center_z,
  input  logic [30:0]         sphere_radius,
  output logic                out_valid,
  output rsi_pkg::mid_item_t  out_item,
  input  logic                out_ready
);
  import rsi_pkg::*;

  logic [FR_STAGES-1:0] vld;
  logic                 fr_en;

  logic [32:0]  oc [3];
  logic [31:0]  dv [3];
  logic [62:0]  dd [3];
  logic [64:0]  dh [3];
  logic [64:0]  cc [3];
  logic [61:0]  rr;

  logic [63:0]  a_f2, a_f3, a_f4, a_f5;
  logic [66:0]  h_f2, h_f3, h_f4, h_f5;
  logic [67:0]  c_f2;
  logic [65:0]  hm, cm;
  logic         cneg_f3, cneg_f4, cneg_f5;
  logic [65:0]  ph_ll, ph_lh, ph_hh;
  logic [65:0]  pc_ll, pc_lh, pc_hl, pc_hh;
  logic [131:0] hsq, acp;
  logic [132:0] disc;

  assign fr_en     = !vld[FR_STAGES-1] || out_ready;
  assign full      = !fr_en;
  assign out_valid = vld[FR_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (fr_en) begin
      vld <= {vld[FR_STAGES-2:0], push};
    end
  end

  // radius square follows the register, ready long before an item needs it
  always_ff @(posedge clk) begin
    rr <= sphere_radius * sphere_radius;
  end

  // c negative means a*c adds to h*h
  assign disc = cneg_f5 ? ({1'b0, hsq} + {1'b0, acp}) : ({1'b0, hsq} - {1'b0, acp});

  always_ff @(posedge clk) begin
    if (fr_en) begin
      oc[0] <= {origin_x[31], origin_x} - {center_x[31], center_x};
      oc[1] <= {origin_y[31], origin_y} - {center_y[31], center_y};
      oc[2] <= {origin_z[31], origin_z} - {center_z[31], center_z};
      dv[0] <= dir_x;
      dv[1] <= dir_y;
      dv[2] <= dir_z;

      for (int i = 0; i < 3; i++) begin
        dd[i] <= 63'($signed(dv[i]) * $signed(dv[i]));
        dh[i] <= 65'($signed(dv[i]) * $signed(oc[i]));
        cc[i] <= 65'($signed(oc[i]) * $signed(oc[i]));
      end

      a_f2 <= 64'(dd[0]) + 64'(dd[1]) + 64'(dd[2]);
      h_f2 <= 67'($signed(dh[0])) + 67'($signed(dh[1])) + 67'($signed(dh[2]));
      c_f2 <= 68'(cc[0]) + 68'(cc[1]) + 68'(cc[2]) - 68'(rr);

      a_f3    <= a_f2;
      h_f3    <= h_f2;
      hm      <= h_f2[66] ? (~h_f2[65:0] + 66'd1) : h_f2[65:0];
      cm      <= c_f2[67] ? (~c_f2[65:0] + 66'd1) : c_f2[65:0];
      cneg_f3 <= c_f2[67];

      // 33-bit limbs, one multiplier each
      a_f4    <= a_f3;
      h_f4    <= h_f3;
      cneg_f4 <= cneg_f3;
      ph_ll   <= hm[32:0] * hm[32:0];
      ph_lh   <= hm[32:0] * hm[65:33];
      ph_hh   <= hm[65:33] * hm[65:33];
      pc_ll   <= a_f3[32:0] * cm[32:0];
      pc_lh   <= a_f3[32:0] * cm[65:33];
      pc_hl   <= {2'b00, a_f3[63:33]} * cm[32:0];
      pc_hh   <= {2'b00, a_f3[63:33]} * cm[65:33];

      a_f5    <= a_f4;
      h_f5    <= h_f4;
      cneg_f5 <= cneg_f4;
      hsq     <= 132'(ph_ll) + (132'(ph_lh) << 34) + (132'(ph_hh) << 66);
      acp     <= 132'(pc_ll) + ((132'(pc_lh) + 132'(pc_hl)) << 33) + (132'(pc_hh) << 66);

      out_item.hit <= (a_f5 != '0) && !disc[132];
      out_item.h   <= h_f5;
      out_item.a   <= a_f5;
      out_item.rad <= disc[131:0];
    end
  end

endmodule

>>> hw/rtl/rsi_back.sv
// back pipeline: square root one bit per stage, then both roots by long division
// depends on rsi_pkg; drains the mid queue into the result queue
module rsi_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  rsi_pkg::mid_item_t  in_item,
  output logic                in_take,
  output logic                out_valid,
  output rsi_pkg::out_item_t  out_item,
  input  logic                out_ready
);
  import rsi_pkg::*;

  localparam int SL = SQ_STAGES - 1;
  localparam int DL = DIV_STAGES - 1;

  logic [BK_STAGES-1:0] vld;
  logic                 bk_en;

  // root stages
  logic [131:0] sq_rad  [SQ_STAGES];
  logic [67:0]  sq_rem  [SQ_STAGES];
  logic [65:0]  sq_root [SQ_STAGES];
  logic [66:0]  sq_h    [SQ_STAGES];
  logic [63:0]  sq_a    [SQ_STAGES];
  logic         sq_hit  [SQ_STAGES];

  // numerator stages
  logic [68:0] hx, sx;
  logic [68:0] nv [2];
  logic [63:0] n1_a, n2_a;
  logic        n1_hit, n2_hit;
  logic [67:0] nm [2];
  logic        nneg [2];

  // division stages, two lanes: near and far
  logic [63:0] d0_rem   [2];
  logic [31:0] d0_low   [2];
  logic        d0_neg   [2];
  logic        d0_large [2];
  logic [63:0] d0_a;
  logic        d0_hit;

  logic [63:0] dv_rem   [DIV_STAGES][2];
  logic [31:0] dv_low   [DIV_STAGES][2];
  logic [31:0] dv_q     [DIV_STAGES][2];
  logic        dv_neg   [DIV_STAGES][2];
  logic        dv_large [DIV_STAGES][2];
  logic [63:0] dv_a     [DIV_STAGES];
  logic        dv_hit   [DIV_STAGES];

  logic [32:0] mag  [2];
  logic [31:0] tval [2];

  assign bk_en     = !vld[BK_STAGES-1] || out_ready;
  assign in_take   = in_valid && bk_en;
  assign out_valid = vld[BK_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (bk_en) begin
      vld <= {vld[BK_STAGES-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sq
    logic [131:0] rad_in;
    logic [67:0]  rem_in;
    logic [65:0]  root_in;
    logic [66:0]  h_in;
    logic [63:0]  a_in;
    logic         hit_in;
    logic [67:0]  rem_sh;
    logic [67:0]  trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rad_in  = in_item.rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign h_in    = in_item.h;
      assign a_in    = in_item.a;
      assign hit_in  = in_item.hit;
    end else begin : g_next
      assign rad_in  = sq_rad[k-1];
      assign rem_in  = sq_rem[k-1];
      assign root_in = sq_root[k-1];
      assign h_in    = sq_h[k-1];
      assign a_in    = sq_a[k-1];
      assign hit_in  = sq_hit[k-1];
    end

    // restoring square root, two radicand bits in per stage
    assign rem_sh = {rem_in[65:0], rad_in[131:130]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (bk_en) begin
        sq_rad[k]  <= {rad_in[129:0], 2'b00};
        sq_rem[k]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_root[k] <= {root_in[64:0], ge};
        sq_h[k]    <= h_in;
        sq_a[k]    <= a_in;
        sq_hit[k]  <= hit_in;
      end
    end
  end

  assign hx = {{2{sq_h[SL][66]}}, sq_h[SL]};
  assign sx = {3'b000, sq_root[SL]};

  always_ff @(posedge clk) begin
    if (bk_en) begin
      // -h - s and -h + s
      nv[0]  <= 69'd0 - hx - sx;
      nv[1]  <= sx - hx;
      n1_a   <= sq_a[SL];
      n1_hit <= sq_hit[SL];

      for (int l = 0; l < 2; l++) begin
        nneg[l] <= nv[l][68];
        nm[l]   <= nv[l][68] ? (~nv[l][67:0] + 68'd1) : nv[l][67:0];
      end
      n2_a   <= n1_a;
      n2_hit <= n1_hit;

      // dividend is magnitude times 2^16; quotient needs 32 bits unless high part >= a
      for (int l = 0; l < 2; l++) begin
        d0_large[l] <= {12'd0, nm[l][67:16]} >= n2_a;
        d0_rem[l]   <= {12'd0, nm[l][67:16]};
        d0_low[l]   <= {nm[l][15:0], 16'd0};
        d0_neg[l]   <= nneg[l];
      end
      d0_a   <= n2_a;
      d0_hit <= n2_hit;
    end
  end

  for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
    logic [63:0] rem_in   [2];
    logic [31:0] low_in   [2];
    logic [31:0] q_in     [2];
    logic        neg_in   [2];
    logic        large_in [2];
    logic [63:0] a_in;
    logic        hit_in;
    logic [64:0] rem_sh   [2];
    logic        ge       [2];

    for (genvar l = 0; l < 2; l++) begin : g_lane
      if (j == 0) begin : g_first
        assign rem_in[l]   = d0_rem[l];
        assign low_in[l]   = d0_low[l];
        assign q_in[l]     = '0;
        assign neg_in[l]   = d0_neg[l];
        assign large_in[l] = d0_large[l];
      end else begin : g_next
        assign rem_in[l]   = dv_rem[j-1][l];
        assign low_in[l]   = dv_low[j-1][l];
        assign q_in[l]     = dv_q[j-1][l];
        assign neg_in[l]   = dv_neg[j-1][l];
        assign large_in[l] = dv_large[j-1][l];
      end
      assign rem_sh[l] = {rem_in[l], low_in[l][31]};
      assign ge[l]     = rem_sh[l] >= {1'b0, a_in};
    end

    if (j == 0) begin : g_first_a
      assign a_in   = d0_a;
      assign hit_in = d0_hit;
    end else begin : g_next_a
      assign a_in   = dv_a[j-1];
      assign hit_in = dv_hit[j-1];
    end

    always_ff @(posedge clk) begin
      if (bk_en) begin
        for (int l = 0; l < 2; l++) begin
          dv_rem[j][l]   <= ge[l] ? 64'(rem_sh[l] - {1'b0, a_in}) : rem_sh[l][63:0];
          dv_low[j][l]   <= {low_in[l][30:0], 1'b0};
          dv_q[j][l]     <= {q_in[l][30:0], ge[l]};
          dv_neg[j][l]   <= neg_in[l];
          dv_large[j][l] <= large_in[l];
        end
        dv_a[j]   <= a_in;
        dv_hit[j] <= hit_in;
      end
    end
  end

  // floor toward minus infinity and saturation
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      mag[l] = {1'b0, dv_q[DL][l]} + {32'd0, dv_rem[DL][l] != '0};
      if (dv_neg[DL][l]) begin
        tval[l] = (dv_large[DL][l] || mag[l][32] || mag[l][31]) ? T_MIN : (~mag[l][31:0] + 32'd1);
      end else begin
        tval[l] = (dv_large[DL][l] || dv_q[DL][l][31]) ? T_MAX : dv_q[DL][l];
      end
    end
  end

  assign out_item.hit    = dv_hit[DL];
  assign out_item.t_near = dv_hit[DL] ? tval[0] : '0;
  assign out_item.t_far  = dv_hit[DL] ? tval[1] : '0;

endmodule

>>> hw/rtl/ray_sphere_intersect.sv
// ray against sphere intersection, fully pipelined, one item per cycle sustained as
// long as results are popped; from the accepting edge of push to empty going low an
// item passes 7 front stages, the mid queue, 66 root stages, 3 numerator stages, 32
// quotient stages and the result queue; root and quotient chains dominate the path
// synchronous reset clears the queues, the valid bits and sets the sphere registers
// to centre 0 and radius one; no clearing pass, items are taken the cycle after reset
module ray_sphere_intersect #(
  parameter int MID_DEPTH = 4,
  parameter int OUT_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  output logic               empty,
  input  logic               pop,
  output logic               hit,
  output logic signed [31:0] t_near,
  output logic signed [31:0] t_far,
  input  logic               cfg_write,
  input  rsi_pkg::cfg_idx_t  cfg_index,
  input  logic [31:0]        cfg_data
);
  import rsi_pkg::*;

  localparam int MID_W = $bits(mid_item_t);
  localparam int OUT_W = $bits(out_item_t);

  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0]        sphere_radius;

  logic              fr_valid;
  mid_item_t         fr_item;
  logic              mq_full, mq_empty;
  logic [MID_W-1:0]  mq_data;
  logic              bk_take;
  logic              bk_valid;
  out_item_t         bk_item;
  logic              oq_full;
  logic [OUT_W-1:0]  oq_data;
  out_item_t         res;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= RADIUS_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:      center_x      <= cfg_data;
        REG_CENTER_Y:      center_y      <= cfg_data;
        REG_CENTER_Z:      center_z      <= cfg_data;
        REG_SPHERE_RADIUS: sphere_radius <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  rsi_front u_front (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .origin_x      (origin_x),
    .origin_y      (origin_y),
    .origin_z      (origin_z),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_z      (center_z),
    .sphere_radius (sphere_radius),
    .out_valid     (fr_valid),
    .out_item      (fr_item),
    .out_ready     (!mq_full)
  );

  rsi_fifo #(
    .DEPTH (MID_DEPTH),
    .WIDTH (MID_W)
  ) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .push    (fr_valid),
    .wr_data (fr_item),
    .full    (mq_full),
    .pop     (bk_take),
    .rd_data (mq_data),
    .empty   (mq_empty)
  );

  rsi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (!mq_empty),
    .in_item   (mid_item_t'(mq_data)),
    .in_take   (bk_take),
    .out_valid (bk_valid),
    .out_item  (bk_item),
    .out_ready (!oq_full)
  );

  rsi_fifo #(
    .DEPTH (OUT_DEPTH),
    .WIDTH (OUT_W)
  ) u_out_q (
    .clk     (clk),
    .rst     (rst),
    .push    (bk_valid),
    .wr_data (bk_item),
    .full    (oq_full),
    .pop     (pop),
    .rd_data (oq_data),
    .empty   (empty)
  );

  assign res    = out_item_t'(oq_data);
  assign hit    = res.hit;
  assign t_near = res.t_near;
  assign t_far  = res.t_far;

endmodule
